// ===== rtl/core/rcd_pkg.sv =====
package rcd_pkg;

    localparam int DATA_W          = 32;
    localparam int PRIME_BITS_DEF  = 16;
    localparam int PRIME_CFG_W     = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_P  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_Q  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 2'd2;

    localparam logic [PRIME_CFG_W-1:0] PRIME_P_RST = 16'd3;
    localparam logic [PRIME_CFG_W-1:0] PRIME_Q_RST = 16'd5;
    localparam logic [DATA_W-1:0]      PRIV_EXP_RST = 32'd1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_R1,
        OP_EUC_DIV,
        OP_EUC_MUL,
        OP_DP,
        OP_DQ,
        OP_CP,
        OP_CQ,
        OP_EXP_ACC,
        OP_EXP_SQR,
        OP_SAVE_M1,
        OP_SAVE_M2,
        OP_M2P,
        OP_H,
        OP_MQ,
        OP_SUM,
        OP_FAIL
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_R1,
        ST_EUC_TEST,
        ST_EUC_DIV,
        ST_EUC_MUL,
        ST_INV_TEST,
        ST_DP,
        ST_DQ,
        ST_CBASE,
        ST_EXP_TEST,
        ST_EXP_ACC,
        ST_EXP_SQR,
        ST_M2P,
        ST_H,
        ST_MQ,
        ST_SUM,
        ST_FAIL,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t  op;
        logic go;
    } cmd_t;

    typedef struct packed {
        logic unit_done;
        logic key_bad;
        logic r1_zero;
        logic r0_one;
        logic exp_zero;
        logic exp_lsb;
    } sts_t;

endpackage

// ===== rtl/core/rsa_crt_decrypt.sv =====
// RSA decryption by the Chinese remainder theorem, one 32-bit word per transaction.
//
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
//   Index 0 writes prime p, index 1 prime q (low 16 bits of the data, kept to
//   PRIME_BITS bits), index 2 the private exponent d. cfg_ready is always high;
//   write only while busy is low. Other indexes are dropped.
// Input: a transaction is taken at a rising edge with start high and busy low;
//   ciphertext is sampled on that edge.
// Output: result_valid is high for exactly one cycle with message and key_error.
//   The receiver cannot stall; it must take the result in that cycle.
//   key_error is 1 (message 0) when p or q is below two or q has no inverse mod p.
// Operation: one item at a time; a new start is not taken while busy. The work
//   runs on two shared sequential units, a restoring divider and an interleaved
//   modular multiplier. Per item: one divide for q mod p, per Euclid round one
//   divide and one multiply, five more divides, up to 2*PRIME_BITS multiplies
//   per exponentiation (two of them), and one multiply for h.
// Reset: asynchronous, active low; p = 3, q = 5, d = 1, block idle.
module rsa_crt_decrypt #(
    parameter int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rcd_pkg::DATA_W-1:0]          ciphertext,
    output logic                                result_valid,
    output logic [rcd_pkg::DATA_W-1:0]          message,
    output logic                                key_error,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rcd_pkg::DATA_W-1:0]          cfg_data
);

    logic [PRIME_BITS-1:0]      p_reg, p_next;
    logic [PRIME_BITS-1:0]      q_reg, q_next;
    logic [rcd_pkg::DATA_W-1:0] d_reg, d_next;
    logic                       cfg_wr;
    rcd_pkg::cmd_t              cmd;
    rcd_pkg::sts_t              sts;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // register file decode; primes take the low configured bits only
    always_comb
    begin
        p_next = p_reg;
        q_next = q_reg;
        d_next = d_reg;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                rcd_pkg::CFG_PRIME_P:  p_next = PRIME_BITS'(cfg_data[rcd_pkg::PRIME_CFG_W-1:0]);
                rcd_pkg::CFG_PRIME_Q:  q_next = PRIME_BITS'(cfg_data[rcd_pkg::PRIME_CFG_W-1:0]);
                rcd_pkg::CFG_PRIV_EXP: d_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= PRIME_BITS'(rcd_pkg::PRIME_P_RST);
            q_reg <= PRIME_BITS'(rcd_pkg::PRIME_Q_RST);
            d_reg <= rcd_pkg::PRIV_EXP_RST;
        end
        else
        begin
            p_reg <= p_next;
            q_reg <= q_next;
            d_reg <= d_next;
        end
    end

    rcd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .sts          (sts),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    rcd_datapath #(.PRIME_BITS(PRIME_BITS)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .p_val      (p_reg),
        .q_val      (q_reg),
        .d_val      (d_reg),
        .ciphertext (ciphertext),
        .message    (message),
        .key_error  (key_error)
    );

endmodule

// ===== rtl/core/rcd_div.sv =====
module rcd_div #(
    parameter int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [rcd_pkg::DATA_W-1:0] dividend,
    input  logic [PRIME_BITS-1:0]     divisor,
    output logic                      done,
    output logic [rcd_pkg::DATA_W-1:0] quot,
    output logic [PRIME_BITS-1:0]     rem
);

    localparam int DW = rcd_pkg::DATA_W;
    localparam int CW = $clog2(DW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [PRIME_BITS-1:0] rem_reg, rem_next;
    logic [PRIME_BITS-1:0] div_reg, div_next;
    logic [PRIME_BITS:0]   trial;
    logic [PRIME_BITS:0]   diff;
    logic                  fits;

    // one restoring step per cycle, quotient bits shift in where the dividend leaves
    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? diff[PRIME_BITS-1:0] : trial[PRIME_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/rcd_mmul.sv =====
module rcd_mmul #(
    parameter int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [PRIME_BITS-1:0] op_a,
    input  logic [PRIME_BITS-1:0] op_b,
    input  logic [PRIME_BITS-1:0] modulus,
    output logic                  done,
    output logic [PRIME_BITS-1:0] product
);

    localparam int CW = $clog2(PRIME_BITS);
    localparam int AW = PRIME_BITS + 2;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [PRIME_BITS-1:0] a_reg, a_next;
    logic [PRIME_BITS-1:0] b_reg, b_next;
    logic [PRIME_BITS-1:0] m_reg, m_next;
    logic [PRIME_BITS-1:0] acc_reg, acc_next;
    logic [AW-1:0]         dbl, s1, s2, mx;

    // MSB-first interleaved multiply: double, reduce, add, reduce
    always_comb
    begin
        mx  = AW'(m_reg);
        dbl = AW'({acc_reg, 1'b0});
        s1  = (dbl >= mx) ? dbl - mx : dbl;
        s2  = s1 + (a_reg[PRIME_BITS-1] ? AW'(b_reg) : '0);
        s2  = (s2 >= mx) ? s2 - mx : s2;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            m_next    = modulus;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = s2[PRIME_BITS-1:0];
            a_next   = a_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(PRIME_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/core/rcd_datapath.sv =====
module rcd_datapath #(
    parameter int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rcd_pkg::cmd_t              cmd,
    output rcd_pkg::sts_t              sts,
    input  logic [PRIME_BITS-1:0]      p_val,
    input  logic [PRIME_BITS-1:0]      q_val,
    input  logic [rcd_pkg::DATA_W-1:0] d_val,
    input  logic [rcd_pkg::DATA_W-1:0] ciphertext,
    output logic [rcd_pkg::DATA_W-1:0] message,
    output logic                       key_error
);

    localparam int DW = rcd_pkg::DATA_W;
    localparam int PB = PRIME_BITS;

    logic [DW-1:0]   c_reg;
    logic [PB-1:0]   r0_reg, r1_reg, qt_reg, t0_reg, t1_reg;
    logic [PB-1:0]   dp_reg, dq_reg, mod_reg, base_reg, acc_reg, exp_reg;
    logic [PB-1:0]   m1_reg, m2_reg, diff_reg, h_reg;
    logic [2*PB-1:0] prod_reg;
    logic [DW-1:0]   msg_reg;
    logic            err_reg;

    logic            div_go, mul_go, div_done, mul_done, div_op;
    logic [DW-1:0]   div_a, div_quot;
    logic [PB-1:0]   div_b, div_rem;
    logic [PB-1:0]   mul_a, mul_b, mul_m, mul_y;
    logic [PB:0]     m2p_diff, tn_diff;
    logic [63:0]     sum_w;

    always_comb
    begin
        div_op = 1'b1;
        div_a  = DW'(q_val);
        div_b  = p_val;
        unique case (cmd.op)
            rcd_pkg::OP_R1:
            begin
                div_a = DW'(q_val);
                div_b = p_val;
            end
            rcd_pkg::OP_EUC_DIV:
            begin
                div_a = DW'(r0_reg);
                div_b = r1_reg;
            end
            rcd_pkg::OP_DP:
            begin
                div_a = d_val;
                div_b = p_val - 1'b1;
            end
            rcd_pkg::OP_DQ:
            begin
                div_a = d_val;
                div_b = q_val - 1'b1;
            end
            rcd_pkg::OP_CP:
            begin
                div_a = c_reg;
                div_b = p_val;
            end
            rcd_pkg::OP_CQ:
            begin
                div_a = c_reg;
                div_b = q_val;
            end
            rcd_pkg::OP_M2P:
            begin
                div_a = DW'(m2_reg);
                div_b = p_val;
            end
            default:
                div_op = 1'b0;
        endcase
    end

    always_comb
    begin
        mul_a = base_reg;
        mul_b = base_reg;
        mul_m = mod_reg;
        case (cmd.op)
            rcd_pkg::OP_EUC_MUL:
            begin
                mul_a = qt_reg;
                mul_b = t1_reg;
                mul_m = p_val;
            end
            rcd_pkg::OP_EXP_ACC:
            begin
                mul_a = acc_reg;
                mul_b = base_reg;
                mul_m = mod_reg;
            end
            rcd_pkg::OP_H:
            begin
                mul_a = t0_reg;
                mul_b = diff_reg;
                mul_m = p_val;
            end
            default:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
                mul_m = mod_reg;
            end
        endcase
    end

    assign div_go = cmd.go && div_op;
    assign mul_go = cmd.go && !div_op;

    rcd_div #(.PRIME_BITS(PB)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    rcd_mmul #(.PRIME_BITS(PB)) u_mmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mul_m),
        .done    (mul_done),
        .product (mul_y)
    );

    // differences kept modulo p
    assign m2p_diff = (m1_reg >= div_rem) ? {1'b0, m1_reg} - {1'b0, div_rem}
                                          : {1'b0, m1_reg} + {1'b0, p_val} - {1'b0, div_rem};
    assign tn_diff  = (t0_reg >= mul_y) ? {1'b0, t0_reg} - {1'b0, mul_y}
                                        : {1'b0, t0_reg} + {1'b0, p_val} - {1'b0, mul_y};
    assign sum_w    = 64'(prod_reg) + 64'(m2_reg);

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            case (cmd.op)
                rcd_pkg::OP_R1:
                begin
                    r0_reg <= p_val;
                    r1_reg <= div_rem;
                    t0_reg <= '0;
                    t1_reg <= PB'(1);
                end
                rcd_pkg::OP_EUC_DIV:
                begin
                    r0_reg <= r1_reg;
                    r1_reg <= div_rem;
                    qt_reg <= (div_quot == DW'(p_val)) ? '0 : div_quot[PB-1:0];
                end
                rcd_pkg::OP_DP: dp_reg <= div_rem;
                rcd_pkg::OP_DQ: dq_reg <= div_rem;
                rcd_pkg::OP_CP:
                begin
                    base_reg <= div_rem;
                    acc_reg  <= PB'(1);
                    exp_reg  <= dp_reg;
                    mod_reg  <= p_val;
                end
                rcd_pkg::OP_CQ:
                begin
                    base_reg <= div_rem;
                    acc_reg  <= PB'(1);
                    exp_reg  <= dq_reg;
                    mod_reg  <= q_val;
                end
                rcd_pkg::OP_M2P: diff_reg <= m2p_diff[PB-1:0];
                default: ;
            endcase
        end
        if (mul_done)
        begin
            case (cmd.op)
                rcd_pkg::OP_EUC_MUL:
                begin
                    t0_reg <= t1_reg;
                    t1_reg <= tn_diff[PB-1:0];
                end
                rcd_pkg::OP_EXP_ACC: acc_reg <= mul_y;
                rcd_pkg::OP_EXP_SQR:
                begin
                    base_reg <= mul_y;
                    exp_reg  <= exp_reg >> 1;
                end
                rcd_pkg::OP_H: h_reg <= mul_y;
                default: ;
            endcase
        end
        case (cmd.op)
            rcd_pkg::OP_LOAD:    c_reg    <= ciphertext;
            rcd_pkg::OP_SAVE_M1: m1_reg   <= acc_reg;
            rcd_pkg::OP_SAVE_M2: m2_reg   <= acc_reg;
            rcd_pkg::OP_MQ:      prod_reg <= h_reg * q_val;
            rcd_pkg::OP_SUM:     msg_reg  <= sum_w[DW-1:0];
            rcd_pkg::OP_FAIL:    msg_reg  <= '0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_reg <= 1'b0;
        else if (cmd.op == rcd_pkg::OP_SUM)
            err_reg <= 1'b0;
        else if (cmd.op == rcd_pkg::OP_FAIL)
            err_reg <= 1'b1;
    end

    assign sts.unit_done = div_done | mul_done;
    assign sts.key_bad   = (p_val[PB-1:1] == '0) || (q_val[PB-1:1] == '0);
    assign sts.r1_zero   = (r1_reg == '0);
    assign sts.r0_one    = (r0_reg == PB'(1));
    assign sts.exp_zero  = (exp_reg == '0);
    assign sts.exp_lsb   = exp_reg[0];

    assign message   = msg_reg;
    assign key_error = err_reg;

endmodule

// ===== rtl/core/rcd_ctrl.sv =====
module rcd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rcd_pkg::sts_t sts,
    output rcd_pkg::cmd_t cmd,
    output logic          busy,
    output logic          result_valid
);

    rcd_pkg::state_t state_reg, state_next;
    logic            phase_reg, phase_next;
    logic            launched_reg, launched_next;
    logic            unit_state;

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            rcd_pkg::ST_IDLE:
                if (start)
                begin
                    state_next = rcd_pkg::ST_CHECK;
                    phase_next = 1'b0;
                end
            rcd_pkg::ST_CHECK:
                state_next = sts.key_bad ? rcd_pkg::ST_FAIL : rcd_pkg::ST_R1;
            rcd_pkg::ST_R1:
                if (sts.unit_done) state_next = rcd_pkg::ST_EUC_TEST;
            rcd_pkg::ST_EUC_TEST:
                state_next = sts.r1_zero ? rcd_pkg::ST_INV_TEST : rcd_pkg::ST_EUC_DIV;
            rcd_pkg::ST_EUC_DIV:
                if (sts.unit_done) state_next = rcd_pkg::ST_EUC_MUL;
            rcd_pkg::ST_EUC_MUL:
                if (sts.unit_done) state_next = rcd_pkg::ST_EUC_TEST;
            rcd_pkg::ST_INV_TEST:
                state_next = sts.r0_one ? rcd_pkg::ST_DP : rcd_pkg::ST_FAIL;
            rcd_pkg::ST_DP:
                if (sts.unit_done) state_next = rcd_pkg::ST_DQ;
            rcd_pkg::ST_DQ:
                if (sts.unit_done) state_next = rcd_pkg::ST_CBASE;
            rcd_pkg::ST_CBASE:
                if (sts.unit_done) state_next = rcd_pkg::ST_EXP_TEST;
            rcd_pkg::ST_EXP_TEST:
                if (sts.exp_zero)
                begin
                    if (phase_reg)
                        state_next = rcd_pkg::ST_M2P;
                    else
                    begin
                        state_next = rcd_pkg::ST_CBASE;
                        phase_next = 1'b1;
                    end
                end
                else
                    state_next = sts.exp_lsb ? rcd_pkg::ST_EXP_ACC : rcd_pkg::ST_EXP_SQR;
            rcd_pkg::ST_EXP_ACC:
                if (sts.unit_done) state_next = rcd_pkg::ST_EXP_SQR;
            rcd_pkg::ST_EXP_SQR:
                if (sts.unit_done) state_next = rcd_pkg::ST_EXP_TEST;
            rcd_pkg::ST_M2P:
                if (sts.unit_done) state_next = rcd_pkg::ST_H;
            rcd_pkg::ST_H:
                if (sts.unit_done) state_next = rcd_pkg::ST_MQ;
            rcd_pkg::ST_MQ:
                state_next = rcd_pkg::ST_SUM;
            rcd_pkg::ST_SUM:
                state_next = rcd_pkg::ST_DONE;
            rcd_pkg::ST_FAIL:
                state_next = rcd_pkg::ST_DONE;
            rcd_pkg::ST_DONE:
                state_next = rcd_pkg::ST_IDLE;
            default:
                state_next = rcd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op     = rcd_pkg::OP_NONE;
        unit_state = 1'b0;
        unique case (state_reg)
            rcd_pkg::ST_IDLE:
                cmd.op = start ? rcd_pkg::OP_LOAD : rcd_pkg::OP_NONE;
            rcd_pkg::ST_R1:
            begin
                cmd.op     = rcd_pkg::OP_R1;
                unit_state = 1'b1;
            end
            rcd_pkg::ST_EUC_DIV:
            begin
                cmd.op     = rcd_pkg::OP_EUC_DIV;
                unit_state = 1'b1;
            end
            rcd_pkg::ST_EUC_MUL:
            begin
                cmd.op     = rcd_pkg::OP_EUC_MUL;
                unit_state = 1'b1;
            end
            rcd_pkg::ST_DP:
            begin
                cmd.op     = rcd_pkg::OP_DP;
                unit_state = 1'b1;
            end
            rcd_pkg::ST_DQ:
            begin
                cmd.op     = rcd_pkg::OP_DQ;
                unit_state = 1'b1;
            end
            rcd_pkg::ST_CBASE:
            begin
                cmd.op     = phase_reg ? rcd_pkg::OP_CQ : rcd_pkg::OP_CP;
                unit_state = 1'b1;
            end
            rcd_pkg::ST_EXP_TEST:
                if (sts.exp_zero)
                    cmd.op = phase_reg ? rcd_pkg::OP_SAVE_M2 : rcd_pkg::OP_SAVE_M1;
            rcd_pkg::ST_EXP_ACC:
            begin
                cmd.op     = rcd_pkg::OP_EXP_ACC;
                unit_state = 1'b1;
            end
            rcd_pkg::ST_EXP_SQR:
            begin
                cmd.op     = rcd_pkg::OP_EXP_SQR;
                unit_state = 1'b1;
            end
            rcd_pkg::ST_M2P:
            begin
                cmd.op     = rcd_pkg::OP_M2P;
                unit_state = 1'b1;
            end
            rcd_pkg::ST_H:
            begin
                cmd.op     = rcd_pkg::OP_H;
                unit_state = 1'b1;
            end
            rcd_pkg::ST_MQ:   cmd.op = rcd_pkg::OP_MQ;
            rcd_pkg::ST_SUM:  cmd.op = rcd_pkg::OP_SUM;
            rcd_pkg::ST_FAIL: cmd.op = rcd_pkg::OP_FAIL;
            default:          cmd.op = rcd_pkg::OP_NONE;
        endcase
        // launch the shared unit once on entry, hold the command until it reports done
        cmd.go        = unit_state && !launched_reg;
        launched_next = unit_state && !sts.unit_done;
        busy          = (state_reg != rcd_pkg::ST_IDLE);
        result_valid  = (state_reg == rcd_pkg::ST_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rcd_pkg::ST_IDLE;
            phase_reg    <= 1'b0;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            launched_reg <= launched_next;
        end
    end

endmodule

// ===== tb/rsa_crt_decrypt_tb.sv =====
module rsa_crt_decrypt_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF;
    localparam logic [rcd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;   // no register here; write is dropped
    localparam int IDLE_LIMIT = 20000;   // limit on idle cycles before the watchdog stops the run
    localparam int RAND_ITEMS = 220;

    // One pending transaction: either a ciphertext word or a register write.
    typedef struct {
        bit                             is_cfg;
        logic [rcd_pkg::CFG_IDX_W-1:0]  idx;
        logic [rcd_pkg::DATA_W-1:0]     val;
    } txn_t;

    typedef struct {
        logic [rcd_pkg::DATA_W-1:0] msg;
        logic                       kerr;
    } plain_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [rcd_pkg::DATA_W-1:0]      ciphertext;
    logic                            result_valid;
    logic [rcd_pkg::DATA_W-1:0]      message;
    logic                            key_error;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [rcd_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [rcd_pkg::DATA_W-1:0]      cfg_data;

    txn_t   pending_q[$];
    plain_t plain_q[$];

    // Key copy used by the predictor, updated when a register write is taken.
    logic [rcd_pkg::PRIME_CFG_W-1:0] key_p;
    logic [rcd_pkg::PRIME_CFG_W-1:0] key_q;
    logic [rcd_pkg::DATA_W-1:0]      key_d;

    int gap_left;
    int quiet_left;
    int mismatches;
    int words_done;
    int key_faults;
    int cfg_writes;
    int idle_cycles;

    rsa_crt_decrypt #(.PRIME_BITS(PRIME_BITS)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .ciphertext   (ciphertext),
        .result_valid (result_valid),
        .message      (message),
        .key_error    (key_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [rcd_pkg::PRIME_CFG_W-1:0] keep_prime(
        logic [rcd_pkg::DATA_W-1:0] v);
        logic [63:0]                     full;
        logic [rcd_pkg::PRIME_CFG_W-1:0] mask;
        full = (64'd1 << PRIME_BITS) - 64'd1;
        mask = full[rcd_pkg::PRIME_CFG_W-1:0];
        return v[rcd_pkg::PRIME_CFG_W-1:0] & mask;
    endfunction

    // Square and multiply; modulus is at least two and fits in 16 bits.
    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                                longint unsigned m);
        longint unsigned acc;
        acc = 1 % m;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    // Decrypt one word with the current key copy.
    function automatic plain_t crt_decrypt(logic [rcd_pkg::DATA_W-1:0] c);
        longint r0, r1, t0, t1, qt, rn, tn;
        longint unsigned p, q, dp, dq, m1, m2, diff, h, m;
        plain_t res;
        p = key_p;
        q = key_q;
        res.msg = '0;
        res.kerr = 1'b1;
        if (p < 2 || q < 2)
            return res;
        // extended Euclid for q^-1 mod p
        r0 = p;
        r1 = q % p;
        t0 = 0;
        t1 = 1;
        while (r1 != 0)
        begin
            qt = r0 / r1;
            rn = r0 - qt * r1;
            tn = t0 - qt * t1;
            r0 = r1;
            r1 = rn;
            t0 = t1;
            t1 = tn;
        end
        if (r0 != 1)
            return res;
        t0 = t0 % longint'(p);
        if (t0 < 0)
            t0 = t0 + longint'(p);
        dp = key_d % (p - 1);
        dq = key_d % (q - 1);
        m1 = pow_mod(c, dp, p);
        m2 = pow_mod(c, dq, q);
        diff = (m1 + p - (m2 % p)) % p;
        h = (unsigned'(t0) * diff) % p;
        m = m2 + h * q;
        res.msg = m[rcd_pkg::DATA_W-1:0];
        res.kerr = 1'b0;
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 5)
            quiet_left = $urandom_range(5, 30);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    task automatic flag_mismatch(string what, logic [rcd_pkg::DATA_W-1:0] want,
                                 logic [rcd_pkg::DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected 0x%08h, actual 0x%08h", what, want, got);
    endtask

    // Driver: hold each transaction until the handshake takes it, then advance.
    // Register writes wait until no decrypted word is still owed.
    always @(posedge clk or negedge rst_n)
    begin
        txn_t t;
        logic nxt_start;
        logic nxt_cfg;
        if (!rst_n)
        begin
            start      <= 1'b0;
            ciphertext <= '0;
            cfg_valid  <= 1'b0;
            cfg_index  <= rcd_pkg::CFG_PRIME_P;
            cfg_data   <= '0;
            key_p      = rcd_pkg::PRIME_P_RST;
            key_q      = rcd_pkg::PRIME_Q_RST;
            key_d      = rcd_pkg::PRIV_EXP_RST;
            gap_left   = 0;
        end
        else
        begin
            nxt_start = start;
            nxt_cfg   = cfg_valid;
            if (start && !busy)
            begin
                plain_q.push_back(crt_decrypt(ciphertext));
                words_done++;
                nxt_start = 1'b0;
                gap_left  = pick_gap();
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rcd_pkg::CFG_PRIME_P:  key_p = keep_prime(cfg_data);
                    rcd_pkg::CFG_PRIME_Q:  key_q = keep_prime(cfg_data);
                    rcd_pkg::CFG_PRIV_EXP: key_d = cfg_data;
                    default: ;
                endcase
                cfg_writes++;
                nxt_cfg  = 1'b0;
                gap_left = pick_gap();
            end
            if (!nxt_start && !nxt_cfg)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() > 0)
                begin
                    t = pending_q[0];
                    if (!t.is_cfg)
                    begin
                        void'(pending_q.pop_front());
                        ciphertext <= t.val;
                        nxt_start = 1'b1;
                    end
                    else if (plain_q.size() == 0 && !busy && !start)
                    begin
                        void'(pending_q.pop_front());
                        cfg_index <= t.idx;
                        cfg_data  <= t.val;
                        nxt_cfg = 1'b1;
                    end
                end
            end
            start     <= nxt_start;
            cfg_valid <= nxt_cfg;
        end
    end

    // Monitor: every strobe must match the oldest owed result.
    always @(posedge clk)
    begin
        plain_t want;
        if (rst_n && result_valid)
        begin
            if (plain_q.size() == 0)
                flag_mismatch("unexpected result, message", '0, message);
            else
            begin
                want = plain_q.pop_front();
                if (message !== want.msg)
                    flag_mismatch("message", want.msg, message);
                if (key_error !== want.kerr)
                    flag_mismatch("key_error", rcd_pkg::DATA_W'(want.kerr),
                                  rcd_pkg::DATA_W'(key_error));
                if (want.kerr)
                    key_faults++;
            end
        end
    end

    // Watchdog: count cycles with no transaction of any kind.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus plan; fill_p/fill_q track what the key will be when words run.
    logic [rcd_pkg::PRIME_CFG_W-1:0] fill_p;
    logic [rcd_pkg::PRIME_CFG_W-1:0] fill_q;

    task automatic add_cfg(logic [rcd_pkg::CFG_IDX_W-1:0] idx, logic [rcd_pkg::DATA_W-1:0] val);
        txn_t t;
        t.is_cfg = 1'b1;
        t.idx = idx;
        t.val = val;
        pending_q.push_back(t);
        if (idx == rcd_pkg::CFG_PRIME_P)
            fill_p = keep_prime(val);
        else if (idx == rcd_pkg::CFG_PRIME_Q)
            fill_q = keep_prime(val);
    endtask

    task automatic add_word(logic [rcd_pkg::DATA_W-1:0] c);
        txn_t t;
        t.is_cfg = 1'b0;
        t.idx = rcd_pkg::CFG_PRIME_P;
        t.val = c;
        pending_q.push_back(t);
    endtask

    function automatic logic [rcd_pkg::DATA_W-1:0] pick_word();
        longint unsigned n;
        n = longint'(fill_p) * longint'(fill_q);
        if (n >= 1 && $urandom_range(99) < 75)
            return $urandom_range(0, 32'(n - 1));
        return $urandom;
    endfunction

    initial
    begin
        int primes[] = '{2, 3, 5, 7, 11, 13, 17, 251, 257, 4093, 32749, 65519, 65521};
        int n;
        mismatches = 0;
        words_done = 0;
        key_faults = 0;
        cfg_writes = 0;
        quiet_left = 0;
        fill_p = rcd_pkg::PRIME_P_RST;
        fill_q = rcd_pkg::PRIME_Q_RST;

        // reset key: p = 3, q = 5, d = 1
        add_word(0);
        add_word(14);
        add_word(15);
        add_word('1);
        // largest primes, largest exponent, ciphertext at and past p*q
        add_cfg(rcd_pkg::CFG_PRIME_P, 65521);
        add_cfg(rcd_pkg::CFG_PRIME_Q, 65519);
        add_cfg(rcd_pkg::CFG_PRIV_EXP, '1);
        add_word(0);
        add_word(32'd4292870398);   // p*q - 1
        add_word(32'd4292870399);   // p*q
        add_word('1);
        // exponent zero, and exponent a multiple of p-1 and q-1
        add_cfg(rcd_pkg::CFG_PRIV_EXP, 0);
        add_word(12345);
        add_cfg(rcd_pkg::CFG_PRIME_P, 7);
        add_cfg(rcd_pkg::CFG_PRIME_Q, 11);
        add_cfg(rcd_pkg::CFG_PRIV_EXP, 30);
        add_word(76);
        // unused index is dropped; key stays usable
        add_cfg(CFG_UNUSED, $urandom);
        add_word(5);
        // no inverse: p equal to q
        add_cfg(rcd_pkg::CFG_PRIME_Q, 7);
        add_word(3);
        // primes below two
        add_cfg(rcd_pkg::CFG_PRIME_P, 1);
        add_word(3);
        add_cfg(rcd_pkg::CFG_PRIME_P, 0);
        add_word(3);
        add_cfg(rcd_pkg::CFG_PRIME_P, 13);
        add_cfg(rcd_pkg::CFG_PRIME_Q, 1);
        add_word(3);
        add_cfg(rcd_pkg::CFG_PRIME_Q, 0);
        add_word(3);
        // composite but coprime p, upper data bits set on a prime write
        add_cfg(rcd_pkg::CFG_PRIME_P, 32'hFFFF_FFFF);
        add_cfg(rcd_pkg::CFG_PRIME_Q, 32'hABCD_0007);
        add_cfg(rcd_pkg::CFG_PRIV_EXP, 65537);
        add_word(123456789);

        // random keys, each followed by a batch of words
        n = 0;
        while (n < RAND_ITEMS)
        begin
            if ($urandom_range(99) < 75)
            begin
                add_cfg(rcd_pkg::CFG_PRIME_P, primes[$urandom_range(primes.size() - 1)]);
                add_cfg(rcd_pkg::CFG_PRIME_Q, primes[$urandom_range(primes.size() - 1)]);
            end
            else
            begin
                add_cfg(rcd_pkg::CFG_PRIME_P, $urandom);
                add_cfg(rcd_pkg::CFG_PRIME_Q, $urandom);
            end
            add_cfg(rcd_pkg::CFG_PRIV_EXP,
                    ($urandom_range(3) == 0) ? $urandom_range(0, 50) : $urandom);
            repeat ($urandom_range(8, 25))
            begin
                add_word(pick_word());
                n++;
            end
        end

        wait (rst_n);
        while (pending_q.size() != 0 || start || cfg_valid || plain_q.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);

        $display("Decrypted %0d words over %0d register writes, %0d with the key rejected",
                 words_done, cfg_writes, key_faults);
        $display("%0d mismatches, %0d results still owed", mismatches, plain_q.size());
        if (mismatches == 0 && plain_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rcd_pkg.sv
rtl/core/rcd_div.sv
rtl/core/rcd_mmul.sv
rtl/core/rcd_datapath.sv
rtl/core/rcd_ctrl.sv
rtl/core/rsa_crt_decrypt.sv
tb/rsa_crt_decrypt_tb.sv
